@@ rtl/stepper_linear_ramp_profiler_macros.svh @@
// Assertion helpers used by the checker of this block.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef STEPPER_LINEAR_RAMP_PROFILER_MACROS_SVH
`define STEPPER_LINEAR_RAMP_PROFILER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SLRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SLRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/slrp_pkg.sv @@
package slrp_pkg;

    typedef struct packed {
        logic               action;
        logic signed [15:0] target_position;
        logic [15:0]        timer_now;
    } t_in_item;

    typedef struct packed {
        logic               phase_advanced;
        logic [1:0]         phase_index;
        logic [15:0]        compare_value;
        logic               running;
        logic signed [15:0] position;
        logic [15:0]        step_delay;
    } t_out_item;

    typedef struct packed {
        logic [15:0] first_delay;
        logic [15:0] min_delay;
        logic [15:0] start_lead;
    } t_cfg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START_LEAD  = 2'd2;

    localparam logic [15:0] FIRST_DELAY_RST = 16'd50000;
    localparam logic [15:0] MIN_DELAY_RST   = 16'd2500;
    localparam logic [15:0] START_LEAD_RST  = 16'd1000;

    // 24.8 fixed point: half an LSB of the integer delay
    localparam logic [32:0] ROUND_HALF = 33'd128;

    localparam int unsigned DIVIDEND_W = 33;
    localparam int unsigned DIVISOR_W  = 20;
    localparam int unsigned QUOT_W     = 34;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_BEGIN,
        OP_START,
        OP_ADV_CMP,
        OP_DENOM_STEP,
        OP_DIV_START,
        OP_SUB_Q,
        OP_ROUND,
        OP_ENTER_MAX,
        OP_SET_DOWN_MID,
        OP_SET_DOWN_MAX,
        OP_SET_LAST,
        OP_STOP,
        OP_MOVE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctl;

    typedef struct packed {
        logic tick;
        logic same_pos;
        logic mode_max;
        logic not_ramp;
        logic up_at_mid;
        logic at_last;
        logic ml_odd;
        logic not_at_decel;
        logic above_min;
    } t_dp_flag;

    typedef struct packed {
        logic     in_valid;
        logic     out_full;
        logic     div_busy;
        t_dp_flag dp;
    } t_status;

endpackage

@@ rtl/slrp_div.sv @@
module slrp_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [slrp_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic signed [slrp_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                                   o_busy,
    output logic signed [slrp_pkg::QUOT_W-1:0]     o_quot
);

    localparam int unsigned NW = slrp_pkg::DIVIDEND_W;
    localparam int unsigned DW = slrp_pkg::DIVISOR_W;
    localparam int unsigned QW = slrp_pkg::QUOT_W;
    // one step per dividend bit plus a sign fix-up step
    localparam int unsigned CNT_W = $clog2(NW + 2);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_acc;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;
    logic             r_neg;
    logic             r_zero;
    logic [QW-1:0]    r_quot;

    logic [DW:0]      w_sh;
    logic             w_ge;
    logic [DW:0]      w_diff;
    logic [QW-1:0]    w_mag;

    assign w_sh   = {r_rem, r_acc[NW-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};
    assign w_mag  = {1'b0, r_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_acc  <= '0;
            r_rem  <= '0;
            r_div  <= '0;
            r_neg  <= 1'b0;
            r_zero <= 1'b0;
            r_quot <= '0;
        end else if (i_start) begin
            // work on magnitudes, restore the sign at the end
            r_acc  <= i_dividend[NW-1] ? NW'(-i_dividend) : NW'(i_dividend);
            r_div  <= i_divisor[DW-1] ? DW'(-i_divisor) : DW'(i_divisor);
            r_rem  <= '0;
            r_neg  <= i_dividend[NW-1] ^ i_divisor[DW-1];
            r_zero <= (i_divisor == '0);
            r_cnt  <= CNT_LOAD;
        end else if (r_cnt > CNT_W'(1)) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_acc <= {r_acc[NW-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (r_cnt == CNT_W'(1)) begin
            if (r_zero) begin
                r_quot <= '0;
            end else begin
                r_quot <= r_neg ? (~w_mag + QW'(1)) : w_mag;
            end
            r_cnt <= '0;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

@@ rtl/slrp_useq.sv @@
module slrp_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slrp_pkg::t_status i_stat,
    output slrp_pkg::t_ctl    o_ctl
);

    localparam int unsigned PC_W = 5;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_TICK,
        C_SAME_POS,
        C_MODE_MAX,
        C_NOT_RAMP,
        C_UP_AT_MID,
        C_AT_LAST,
        C_ML_ODD,
        C_NOT_AT_DECEL,
        C_ABOVE_MIN,
        C_DIV_BUSY,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        slrp_pkg::t_op    op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] L_FETCH    = 5'd0;
    localparam logic [PC_W-1:0] L_TICK     = 5'd4;
    localparam logic [PC_W-1:0] L_CHKLAST  = 5'd7;
    localparam logic [PC_W-1:0] L_WAIT     = 5'd10;
    localparam logic [PC_W-1:0] L_MID      = 5'd15;
    localparam logic [PC_W-1:0] L_MAX      = 5'd17;
    localparam logic [PC_W-1:0] L_LAST     = 5'd19;
    localparam logic [PC_W-1:0] L_STOP     = 5'd20;
    localparam logic [PC_W-1:0] L_MOVE     = 5'd21;
    localparam logic [PC_W-1:0] L_EMIT     = 5'd22;

    function automatic t_uword rom(input logic [PC_W-1:0] a);
        t_uword w;
        case (a)
            5'd0:  w = '{slrp_pkg::OP_NOP,          C_NO_INPUT,     L_FETCH};
            5'd1:  w = '{slrp_pkg::OP_BEGIN,        C_TICK,         L_TICK};
            5'd2:  w = '{slrp_pkg::OP_NOP,          C_SAME_POS,     L_EMIT};
            5'd3:  w = '{slrp_pkg::OP_START,        C_ALWAYS,       L_EMIT};
            5'd4:  w = '{slrp_pkg::OP_ADV_CMP,      C_MODE_MAX,     L_MAX};
            5'd5:  w = '{slrp_pkg::OP_NOP,          C_NOT_RAMP,     L_STOP};
            5'd6:  w = '{slrp_pkg::OP_NOP,          C_UP_AT_MID,    L_MID};
            5'd7:  w = '{slrp_pkg::OP_NOP,          C_AT_LAST,      L_LAST};
            5'd8:  w = '{slrp_pkg::OP_DENOM_STEP,   C_NEVER,        L_FETCH};
            5'd9:  w = '{slrp_pkg::OP_DIV_START,    C_NEVER,        L_FETCH};
            5'd10: w = '{slrp_pkg::OP_NOP,          C_DIV_BUSY,     L_WAIT};
            5'd11: w = '{slrp_pkg::OP_SUB_Q,        C_NEVER,        L_FETCH};
            5'd12: w = '{slrp_pkg::OP_ROUND,        C_NEVER,        L_FETCH};
            5'd13: w = '{slrp_pkg::OP_NOP,          C_ABOVE_MIN,    L_MOVE};
            5'd14: w = '{slrp_pkg::OP_ENTER_MAX,    C_ALWAYS,       L_MOVE};
            5'd15: w = '{slrp_pkg::OP_SET_DOWN_MID, C_ML_ODD,       L_CHKLAST};
            5'd16: w = '{slrp_pkg::OP_DENOM_STEP,   C_ALWAYS,       L_MOVE};
            5'd17: w = '{slrp_pkg::OP_NOP,          C_NOT_AT_DECEL, L_MOVE};
            5'd18: w = '{slrp_pkg::OP_SET_DOWN_MAX, C_ALWAYS,       L_MOVE};
            5'd19: w = '{slrp_pkg::OP_SET_LAST,     C_ALWAYS,       L_MOVE};
            5'd20: w = '{slrp_pkg::OP_STOP,         C_ALWAYS,       L_EMIT};
            5'd21: w = '{slrp_pkg::OP_MOVE,         C_NEVER,        L_FETCH};
            5'd22: w = '{slrp_pkg::OP_EMIT,         C_OUT_FULL,     L_EMIT};
            default: w = '{slrp_pkg::OP_NOP,        C_ALWAYS,       L_FETCH};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_word;
    logic            w_take;

    assign w_word = rom(r_pc);

    always_comb begin
        unique case (w_word.cond)
            C_NEVER:        w_take = 1'b0;
            C_ALWAYS:       w_take = 1'b1;
            C_NO_INPUT:     w_take = !i_stat.in_valid;
            C_TICK:         w_take = i_stat.dp.tick;
            C_SAME_POS:     w_take = i_stat.dp.same_pos;
            C_MODE_MAX:     w_take = i_stat.dp.mode_max;
            C_NOT_RAMP:     w_take = i_stat.dp.not_ramp;
            C_UP_AT_MID:    w_take = i_stat.dp.up_at_mid;
            C_AT_LAST:      w_take = i_stat.dp.at_last;
            C_ML_ODD:       w_take = i_stat.dp.ml_odd;
            C_NOT_AT_DECEL: w_take = i_stat.dp.not_at_decel;
            C_ABOVE_MIN:    w_take = i_stat.dp.above_min;
            C_DIV_BUSY:     w_take = i_stat.div_busy;
            C_OUT_FULL:     w_take = i_stat.out_full;
            default:        w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : (r_pc + PC_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.op   = w_word.op;
    assign o_ctl.idle = (r_pc == L_FETCH);

endmodule

@@ rtl/slrp_dp.sv @@
module slrp_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  slrp_pkg::t_op                          i_op,
    input  slrp_pkg::t_cfg                         i_cfg,
    input  slrp_pkg::t_in_item                     i_in,
    input  logic signed [slrp_pkg::QUOT_W-1:0]     i_quot,
    output logic signed [slrp_pkg::DIVIDEND_W-1:0] o_dividend,
    output logic signed [slrp_pkg::DIVISOR_W-1:0]  o_divisor,
    output slrp_pkg::t_dp_flag                     o_flag,
    output slrp_pkg::t_out_item                    o_res
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_UP   = 3'd1,
        MODE_MAX  = 3'd2,
        MODE_DOWN = 3'd3,
        MODE_LAST = 3'd4
    } t_mode;

    t_mode              r_mode;
    logic [15:0]        r_abs_pos;
    logic               r_dir_down;
    logic [1:0]         r_phase;
    logic [15:0]        r_next_cmp;
    logic [15:0]        r_delay_int;
    logic [31:0]        r_delay_fix;
    logic [15:0]        r_steps;
    logic [15:0]        r_decel;
    logic [15:0]        r_ml;
    logic [15:0]        r_mid;
    logic [19:0]        r_denom;
    logic               r_run;
    logic               r_stepped;

    logic signed [15:0] w_pos;
    logic [15:0]        w_tgt;
    logic               w_below;
    logic [15:0]        w_ml_new;
    logic [15:0]        w_mid_new;
    logic [1:0]         w_ph_up;
    logic [1:0]         w_ph_dn;
    logic [16:0]        w_diff;
    logic [19:0]        w_seed;
    logic [33:0]        w_nc;
    logic [31:0]        w_fix_sat;
    logic [32:0]        w_rs;
    logic [15:0]        w_dint;

    assign w_pos     = r_abs_pos;
    assign w_tgt     = i_in.target_position;
    assign w_below   = (i_in.target_position < w_pos);
    assign w_ml_new  = w_below ? (r_abs_pos - w_tgt) : (w_tgt - r_abs_pos);
    assign w_mid_new = (w_ml_new - 16'd1) >> 1;
    assign w_ph_up   = r_phase + 2'd1;
    assign w_ph_dn   = r_phase - 2'd1;

    // (steps - length) * 4, kept to the 20-bit denominator
    assign w_diff = {1'b0, r_steps} - {1'b0, r_ml};
    assign w_seed = {w_diff[16], w_diff, 2'b00};

    // c -= 2c/denom, saturated to the signed 32-bit range
    assign w_nc = {{2{r_delay_fix[31]}}, r_delay_fix} - i_quot;
    always_comb begin
        if (w_nc[33:31] == 3'b000 || w_nc[33:31] == 3'b111) begin
            w_fix_sat = w_nc[31:0];
        end else if (w_nc[33]) begin
            w_fix_sat = 32'h8000_0000;
        end else begin
            w_fix_sat = 32'h7FFF_FFFF;
        end
    end

    // round 24.8 to integer, clamp to 0..65535
    assign w_rs = {r_delay_fix[31], r_delay_fix} + slrp_pkg::ROUND_HALF;
    always_comb begin
        if (w_rs[32]) begin
            w_dint = 16'd0;
        end else if (w_rs[31:24] != 8'd0) begin
            w_dint = 16'hFFFF;
        end else begin
            w_dint = w_rs[23:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_abs_pos   <= '0;
            r_dir_down  <= 1'b0;
            r_phase     <= '0;
            r_next_cmp  <= '0;
            r_delay_int <= '0;
            r_delay_fix <= '0;
            r_steps     <= '0;
            r_decel     <= '0;
            r_ml        <= '0;
            r_mid       <= '0;
            r_denom     <= '0;
            r_run       <= 1'b0;
            r_stepped   <= 1'b0;
        end else begin
            unique case (i_op)
                slrp_pkg::OP_BEGIN: begin
                    r_stepped <= 1'b0;
                end
                slrp_pkg::OP_START: begin
                    r_ml        <= w_ml_new;
                    r_mid       <= w_mid_new;
                    r_dir_down  <= w_below;
                    r_delay_int <= i_cfg.first_delay;
                    r_delay_fix <= {8'd0, i_cfg.first_delay, 8'd0};
                    r_steps     <= '0;
                    r_denom     <= 20'd1;
                    r_mode      <= MODE_UP;
                    r_run       <= 1'b1;
                    r_next_cmp  <= i_in.timer_now + i_cfg.start_lead;
                    r_phase     <= w_below ? w_ph_dn : w_ph_up;
                    r_stepped   <= 1'b1;
                end
                slrp_pkg::OP_ADV_CMP: begin
                    r_next_cmp <= r_next_cmp + r_delay_int;
                end
                slrp_pkg::OP_DENOM_STEP: begin
                    r_denom <= r_denom + 20'd4;
                end
                slrp_pkg::OP_SUB_Q: begin
                    r_delay_fix <= w_fix_sat;
                end
                slrp_pkg::OP_ROUND: begin
                    r_delay_int <= w_dint;
                end
                slrp_pkg::OP_ENTER_MAX: begin
                    r_mode      <= MODE_MAX;
                    r_decel     <= r_ml - r_steps;
                    r_delay_int <= i_cfg.min_delay;
                end
                slrp_pkg::OP_SET_DOWN_MID: begin
                    r_mode  <= MODE_DOWN;
                    r_denom <= w_seed + 20'd1;
                end
                slrp_pkg::OP_SET_DOWN_MAX: begin
                    r_mode  <= MODE_DOWN;
                    r_denom <= w_seed + 20'd5;
                end
                slrp_pkg::OP_SET_LAST: begin
                    r_mode <= MODE_LAST;
                end
                slrp_pkg::OP_STOP: begin
                    r_mode <= MODE_IDLE;
                    r_run  <= 1'b0;
                end
                slrp_pkg::OP_MOVE: begin
                    r_abs_pos <= r_dir_down ? (r_abs_pos - 16'd1) : (r_abs_pos + 16'd1);
                    r_steps   <= r_steps + 16'd1;
                    if (r_mode != MODE_LAST) begin
                        r_phase   <= r_dir_down ? w_ph_dn : w_ph_up;
                        r_stepped <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_dividend = {r_delay_fix, 1'b0};
    assign o_divisor  = r_denom;

    assign o_flag.tick         = i_in.action;
    assign o_flag.same_pos     = (w_tgt == r_abs_pos);
    assign o_flag.mode_max     = (r_mode == MODE_MAX);
    assign o_flag.not_ramp     = (r_mode != MODE_UP) && (r_mode != MODE_DOWN);
    assign o_flag.up_at_mid    = (r_mode == MODE_UP) && (r_steps == r_mid);
    assign o_flag.at_last      = (r_steps == (r_ml - 16'd1));
    assign o_flag.ml_odd       = r_ml[0];
    assign o_flag.not_at_decel = (r_steps != r_decel);
    assign o_flag.above_min    = (r_delay_int > i_cfg.min_delay);

    assign o_res.phase_advanced = r_stepped;
    assign o_res.phase_index    = r_phase;
    assign o_res.compare_value  = r_next_cmp;
    assign o_res.running        = r_run;
    assign o_res.position       = r_abs_pos;
    assign o_res.step_delay     = r_delay_int;

endmodule

@@ rtl/stepper_linear_ramp_profiler.sv @@
// Transfer in to o_out_valid: a start to the current position goes straight to the result, any
// other start loads the move first, a tick steps a running move with or without a ramp update.
// A ramp update waits on the serial divider: 33 quotient bits plus a sign fix-up step.
// Throughput: one item at a time, the next transfer only after the result is loaded.
// Reset is synchronous, active low: clears the move state, loads the default
// configuration (50000, 2500, 1000); there is no clearing pass.
module stepper_linear_ramp_profiler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  slrp_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output slrp_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [slrp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [15:0]                          i_cfg_data
);

    slrp_pkg::t_cfg      r_cfg;
    slrp_pkg::t_in_item  r_in;
    logic                r_out_valid;
    slrp_pkg::t_out_item r_out;

    slrp_pkg::t_ctl      w_ctl;
    slrp_pkg::t_status   w_stat;
    slrp_pkg::t_dp_flag  w_flag;
    slrp_pkg::t_out_item w_res;
    logic signed [slrp_pkg::DIVIDEND_W-1:0] w_dividend;
    logic signed [slrp_pkg::DIVISOR_W-1:0]  w_divisor;
    logic signed [slrp_pkg::QUOT_W-1:0]     w_quot;
    logic                w_div_busy;
    logic                w_in_xfer;
    logic                w_out_xfer;

    assign w_in_xfer  = i_in_valid && w_ctl.idle;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    assign w_stat.in_valid = i_in_valid;
    assign w_stat.out_full = r_out_valid;
    assign w_stat.div_busy = w_div_busy;
    assign w_stat.dp       = w_flag;

    slrp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    slrp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_ctl.op),
        .i_cfg      (r_cfg),
        .i_in       (r_in),
        .i_quot     (w_quot),
        .o_dividend (w_dividend),
        .o_divisor  (w_divisor),
        .o_flag     (w_flag),
        .o_res      (w_res)
    );

    slrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctl.op == slrp_pkg::OP_DIV_START),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_delay <= slrp_pkg::FIRST_DELAY_RST;
            r_cfg.min_delay   <= slrp_pkg::MIN_DELAY_RST;
            r_cfg.start_lead  <= slrp_pkg::START_LEAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                slrp_pkg::CFG_IDX_FIRST_DELAY: r_cfg.first_delay <= i_cfg_data;
                slrp_pkg::CFG_IDX_MIN_DELAY:   r_cfg.min_delay   <= i_cfg_data;
                slrp_pkg::CFG_IDX_START_LEAD:  r_cfg.start_lead  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
        if (w_ctl.op == slrp_pkg::OP_EMIT && !r_out_valid) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.op == slrp_pkg::OP_EMIT && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = !w_ctl.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/slrp_chk.sv @@
`include "stepper_linear_ramp_profiler_macros.svh"

module slrp_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input slrp_pkg::t_out_item o_out_data
);

    `SLRP_ASSERT_NEXT(a_out_valid_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `SLRP_ASSERT_NEXT(a_out_data_hold, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")
    `SLRP_ASSERT_NEXT(a_busy_after_in, i_in_valid && !o_in_stall, o_in_stall, "second transfer taken while an item is in work")
    `SLRP_ASSERT_NOW(a_step_running, o_out_valid && o_out_data.phase_advanced, o_out_data.running, "phase stepped with no move running")

endmodule

bind stepper_linear_ramp_profiler slrp_chk u_slrp_chk (.*);

@@ tb/tb_stepper_linear_ramp_profiler.sv @@
`timescale 1ns / 1ps

module tb_stepper_linear_ramp_profiler;
    import slrp_pkg::*;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;
    localparam int   PLAN_LEN  = 17;

    typedef enum logic [2:0] {RM_IDLE, RM_UP, RM_MAX, RM_DOWN, RM_LAST} ramp_mode_t;

    typedef struct packed {
        logic      known;
        t_in_item  item;
        t_out_item want;
    } plan_row_t;

    // Directed opening: rows with known = 1 carry a hand-derived result
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // tick while idle: compare moves by the zero delay, nothing else
        '{1'b1, '{ACT_TICK, 16'sh7FFF, 16'hFFFF}, '{1'b0, 2'd0, 16'd0, 1'b0, 16'sd0, 16'd0}},
        // target equals position
        '{1'b1, '{ACT_START, 16'sh0000, 16'hFFFF}, '{1'b0, 2'd0, 16'd0, 1'b0, 16'sd0, 16'd0}},
        // most negative target, compare wraps past the top of the timer
        '{1'b1, '{ACT_START, 16'sh8000, 16'hFFFF},
            '{1'b1, 2'd3, 16'd999, 1'b1, 16'sd0, 16'd50000}},
        // restart while running, most positive target
        '{1'b1, '{ACT_START, 16'sh7FFF, 16'h0000},
            '{1'b1, 2'd0, 16'd1000, 1'b1, 16'sd0, 16'd50000}},
        '{1'b0, '{ACT_TICK, 16'sh8000, 16'h0000}, '0},
        '{1'b0, '{ACT_TICK, 16'sh5555, 16'hAAAA}, '0},
        // even-length move: midpoint turn without a ramp update, then last, then idle
        '{1'b0, '{ACT_START, 16'sh0004, 16'h1234}, '0},
        '{1'b0, '{ACT_TICK, 16'shAAAA, 16'h5555}, '0},
        '{1'b0, '{ACT_TICK, 16'sh0000, 16'hFFFF}, '0},
        '{1'b0, '{ACT_TICK, 16'sh7FFF, 16'h0000}, '0},
        '{1'b0, '{ACT_TICK, 16'sh8000, 16'hFFFF}, '0},
        // odd-length move downward
        '{1'b0, '{ACT_START, 16'sh0001, 16'h0000}, '0},
        '{1'b0, '{ACT_TICK, 16'sh1111, 16'h2222}, '0},
        '{1'b0, '{ACT_TICK, 16'sh3333, 16'h4444}, '0},
        '{1'b0, '{ACT_TICK, 16'sh6666, 16'h7777}, '0},
        '{1'b0, '{ACT_TICK, 16'sh0000, 16'h0000}, '0},
        '{1'b0, '{ACT_START, 16'sh0001, 16'hFFFF}, '0}
    };

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_IDX_FIRST_DELAY;
    logic [15:0]          i_cfg_data = '0;

    // predictor copy of the move state and configuration
    logic [15:0]        cfg_first  = FIRST_DELAY_RST;
    logic [15:0]        cfg_min    = MIN_DELAY_RST;
    logic [15:0]        cfg_lead   = START_LEAD_RST;
    ramp_mode_t         mode_q     = RM_IDLE;
    logic signed [15:0] pos_q      = '0;
    logic               down_q     = 1'b0;
    logic [1:0]         phase_q    = '0;
    logic [15:0]        cmp_q      = '0;
    logic [15:0]        delay_q    = '0;
    int                 delay_fx_q = 0;
    logic [15:0]        steps_q    = '0;
    logic [15:0]        decel_q    = '0;
    logic [15:0]        len_q      = '0;
    logic [15:0]        mid_q      = '0;
    int                 denom_q    = 0;
    logic               run_q      = 1'b0;

    t_out_item status_due[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    bit        no_idle      = 1'b0;

    stepper_linear_ramp_profiler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit idle_roll();
        return !no_idle && ($urandom_range(99) < 23);
    endfunction

    function automatic int wrap20(input longint v);
        logic [19:0] low;
        low = v[19:0];
        return {{12{low[19]}}, low};
    endfunction

    function automatic void step_phase();
        phase_q = phase_q + (down_q ? 2'd3 : 2'd1);
    endfunction

    // one ramp update of the 24.8 delay; clamp at the minimum enters cruise
    function automatic void update_delay();
        longint quot;
        longint nxt;
        longint rounded;
        denom_q = wrap20(longint'(denom_q) + 4);
        quot = 0;
        if (denom_q != 0)
            quot = (longint'(delay_fx_q) * 2) / longint'(denom_q);
        nxt = longint'(delay_fx_q) - quot;
        if (nxt > 64'sd2147483647)
            nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648)
            nxt = -64'sd2147483648;
        delay_fx_q = int'(nxt);
        rounded = (nxt + 128) / 256;
        if (rounded < 0)
            rounded = 0;
        if (rounded > 65535)
            rounded = 65535;
        delay_q = rounded[15:0];
        if (delay_q <= cfg_min) begin
            mode_q  = RM_MAX;
            decel_q = len_q - steps_q;
            delay_q = cfg_min;
        end
    endfunction

    function automatic t_out_item advance_profile(input t_in_item it);
        t_out_item   res;
        logic        stepped;
        logic        turned_even;
        int          tgt;
        int          cur;
        int          sd;
        int          ml;
        logic [15:0] last_idx;
        stepped = 1'b0;
        if (it.action == ACT_START) begin
            tgt = int'($signed(it.target_position));
            cur = int'(pos_q);
            if (tgt != cur) begin
                if (tgt < cur) begin
                    len_q  = 16'(cur - tgt);
                    down_q = 1'b1;
                end else begin
                    len_q  = 16'(tgt - cur);
                    down_q = 1'b0;
                end
                mid_q      = (len_q - 16'd1) >> 1;
                delay_q    = cfg_first;
                delay_fx_q = {8'd0, cfg_first, 8'd0};
                steps_q    = '0;
                denom_q    = 1;
                mode_q     = RM_UP;
                run_q      = 1'b1;
                cmp_q      = it.timer_now + cfg_lead;
                step_phase();
                stepped = 1'b1;
            end
        end else begin
            last_idx    = len_q - 16'd1;
            sd          = int'(steps_q);
            ml          = int'(len_q);
            turned_even = 1'b0;
            cmp_q       = cmp_q + delay_q;
            case (mode_q)
                RM_UP, RM_DOWN: begin
                    if (mode_q == RM_UP && steps_q == mid_q) begin
                        mode_q  = RM_DOWN;
                        denom_q = wrap20(longint'((sd - ml) * 4 + 1));
                        // even length: hold the delay across the turn
                        if (!len_q[0]) begin
                            denom_q     = wrap20(longint'(denom_q) + 4);
                            turned_even = 1'b1;
                        end
                    end
                    if (!turned_even) begin
                        if (steps_q == last_idx)
                            mode_q = RM_LAST;
                        else
                            update_delay();
                    end
                end
                RM_MAX: begin
                    if (steps_q == decel_q) begin
                        mode_q  = RM_DOWN;
                        denom_q = wrap20(longint'((sd - ml) * 4 + 5));
                    end
                end
                default: begin
                    mode_q = RM_IDLE;
                    run_q  = 1'b0;
                end
            endcase
            if (mode_q != RM_IDLE) begin
                pos_q   = down_q ? pos_q - 16'sd1 : pos_q + 16'sd1;
                steps_q = steps_q + 16'd1;
                if (mode_q != RM_LAST) begin
                    step_phase();
                    stepped = 1'b1;
                end
            end
        end
        res.phase_advanced = stepped;
        res.phase_index    = phase_q;
        res.compare_value  = cmp_q;
        res.running        = run_q;
        res.position       = pos_q;
        res.step_delay     = delay_q;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH result %0d at %0t: %s", results_seen, $time, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_status(input t_out_item got);
        t_out_item want;
        if (status_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = status_due.pop_front();
        check_field("phase_advanced", longint'(got.phase_advanced),
                    longint'(want.phase_advanced));
        check_field("phase_index", longint'(got.phase_index), longint'(want.phase_index));
        check_field("compare_value", longint'(got.compare_value),
                    longint'(want.compare_value));
        check_field("running", longint'(got.running), longint'(want.running));
        check_field("position", longint'($signed(got.position)),
                    longint'($signed(want.position)));
        check_field("step_delay", longint'(got.step_delay), longint'(want.step_delay));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_status(o_out_data);
            results_seen++;
        end
    end

    always @(posedge i_clk)
        i_out_stall <= idle_roll();

    task automatic send_item(input t_in_item it);
        if (idle_roll()) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_roll());
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        status_due.push_back(advance_profile(it));
    endtask

    // stop sending and wait out every pending result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_IDX_FIRST_DELAY: cfg_first = val;
            CFG_IDX_MIN_DELAY:   cfg_min   = val;
            CFG_IDX_START_LEAD:  cfg_lead  = val;
            default: ;
        endcase
    endtask

    task automatic load_profile(input logic [15:0] first, input logic [15:0] min_d,
                                input logic [15:0] lead);
        drain();
        write_cfg(CFG_IDX_FIRST_DELAY, first);
        write_cfg(CFG_IDX_MIN_DELAY, min_d);
        write_cfg(CFG_IDX_START_LEAD, lead);
    endtask

    function automatic t_in_item start_item(input int tgt);
        t_in_item it;
        it.action          = ACT_START;
        it.target_position = tgt[15:0];
        it.timer_now       = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item tick_item();
        t_in_item it;
        it.action          = ACT_TICK;
        it.target_position = 16'($urandom);
        it.timer_now       = 16'($urandom);
        return it;
    endfunction

    // mostly complete moves with random content; some noise, cut-short
    // moves (restarted by the next start) and extra ticks while idle
    task automatic run_moves(input int budget);
        int sent;
        int span;
        int ticks;
        int tgt;
        int roll;
        t_in_item noise;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                noise.action          = 1'($urandom_range(1));
                noise.target_position = 16'($urandom);
                noise.timer_now       = 16'($urandom);
                send_item(noise);
                sent++;
            end else begin
                roll = $urandom_range(99);
                if (roll < 80)
                    span = $urandom_range(24, 1);
                else if (roll < 97)
                    span = $urandom_range(160, 25);
                else
                    span = $urandom_range(400, 161);
                // keep the last move inside the budget
                if (span > budget - sent)
                    span = budget - sent;
                tgt = $signed(pos_q) + ($urandom_range(1) ? span : -span);
                if (tgt > 32767 || tgt < -32768)
                    tgt = 2 * $signed(pos_q) - tgt;
                if ($urandom_range(99) < 4)
                    tgt = $signed(pos_q);
                send_item(start_item(tgt));
                ticks = span + 1;
                roll  = $urandom_range(99);
                if (roll < 10)
                    ticks = $urandom_range(span, 0);
                else if (roll < 20)
                    ticks += $urandom_range(3, 1);
                repeat (ticks) send_item(tick_item());
                sent += ticks + 1;
                if ($urandom_range(99) < 5)
                    drain();
            end
        end
    endtask

    initial begin
        logic [15:0] first;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            send_item(PLAN[i].item);
            if (PLAN[i].known)
                status_due[status_due.size() - 1] = PLAN[i].want;
        end

        // quick ramp into cruise, no lead
        load_profile(16'd3000, 16'd1000, 16'd0);
        run_moves(200);

        // steepest ramp that never cruises, largest lead
        load_profile(16'hFFFF, 16'd1, 16'hFFFF);
        run_moves(200);

        // first delay below the minimum: cruise from the first update
        no_idle = 1'b1;
        load_profile(16'd1, 16'hFFFF, 16'd12345);
        run_moves(150);
        no_idle = 1'b0;

        repeat (4) begin
            first = 16'($urandom_range(65535, 1));
            load_profile(first,
                         $urandom_range(1) ? 16'($urandom_range(65535, 1))
                                           : 16'($urandom_range(first / 8 + 1, 1)),
                         16'($urandom));
            run_moves(60);
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
